### sv/bdis_pkg.sv
`default_nettype none
package bdis_pkg;

   typedef struct packed {
      logic [11:0] sample_code;
      logic [47:0] timestamp_ns;
      logic        last;
   } req_payload_type;

   typedef struct packed {
      logic [9:0]  dip_count;
      logic [47:0] shortest_gap;
      logic [47:0] longest_gap;
      logic [47:0] mean_interval;
      logic [11:0] min_sample;
      logic [11:0] max_sample;
      logic [27:0] average_level;
   } rsp_payload_type;

   localparam logic [1:0] CSR_DIP_THRESHOLD  = 2'd0;
   localparam logic [1:0] CSR_RELEASE_MARGIN = 2'd1;
   localparam logic [1:0] CSR_EMA_ALPHA      = 2'd2;

   localparam logic [11:0] DIP_THRESHOLD_RESET  = 12'd228;
   localparam logic [11:0] RELEASE_MARGIN_RESET = 12'd68;
   localparam logic [15:0] EMA_ALPHA_RESET      = 16'd66;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture accepted transaction and update stats
      logic ema_apply;  // apply registered average product
      logic scan_start; // clear scan counters, issue first read
      logic scan_step;  // evaluate one read sample, issue next read
      logic div_start;  // start mean division
      logic rsp_load;   // capture result
   } bdis_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic stored;     // the loaded sample was kept
      logic last;       // the loaded sample closes the batch
      logic scan_done;  // no stored sample is left to evaluate
      logic div_busy;
   } bdis_sts_type;

endpackage
`default_nettype wire

### sv/batch_dip_and_interval_stats.sv
// Batch dip and interval statistics.
// Input channel req_*: one light sample per transaction, with timestamp and a
// last flag. Each transaction has a load step (store write, stats, product
// register) and then an average update step; req_stall is high in the latter.
// A transaction with last set starts the dip scan: one stored sample per cycle
// through the single read port of the sample memory, then a mean division
// (one quotient bit a cycle). The result is then held in an output register on
// rsp_*. If the receiver stalls the result, it holds in the register and the
// block waits before writing the next one. New samples are still taken while
// a stalled result is held, but not while the block waits to write the next
// one, nor during the scan and division.
// Samples past BATCH_DEPTH are dropped; their last flag still closes the batch.
// csr_*: write dip_threshold, release_margin and ema_alpha only while idle.
// Synchronous reset clears all statistics and restores register defaults;
// the sample memory needs no clearing.
`default_nettype none
module batch_dip_and_interval_stats #(
   parameter int BATCH_DEPTH = 1024
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire bdis_pkg::req_payload_type   req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output bdis_pkg::rsp_payload_type        rsp_data,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [1:0]                  csr_index,
   input  wire logic [15:0]                 csr_data
);
   import bdis_pkg::*;

   bdis_cmd_type cmd;
   bdis_sts_type sts;
   logic [11:0]  thr_ff, margin_ff;
   logic [15:0]  alpha_ff;

   assign csr_ready = 1'b1;

   // hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= DIP_THRESHOLD_RESET;
         margin_ff <= RELEASE_MARGIN_RESET;
         alpha_ff  <= EMA_ALPHA_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DIP_THRESHOLD:  thr_ff    <= csr_data[11:0];
            CSR_RELEASE_MARGIN: margin_ff <= csr_data[11:0];
            CSR_EMA_ALPHA:      alpha_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   bdis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bdis_dp #(.BATCH_DEPTH(BATCH_DEPTH)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .thr      (thr_ff),
      .margin   (margin_ff),
      .alpha    (alpha_ff),
      .rsp_data (rsp_data)
   );
endmodule
`default_nettype wire

### sv/bdis_ram.sv
`default_nettype none
module bdis_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### sv/bdis_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module bdis_div #(
   parameter int NW = 58,
   parameter int DW = 17
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] numer,
   input  wire logic [DW-1:0] denom,
   output logic               busy,
   output logic      [NW-1:0] quot
);
   localparam int CW = $clog2(NW + 1);
   logic [CW-1:0] cnt_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] den_ff;
   logic [DW:0]   trial;

   assign busy  = (cnt_ff != '0);
   assign trial = {rem_ff, quot[NW-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CW'(NW);
         quot   <= numer;
         rem_ff <= '0;
         den_ff <= denom;
      end else if (busy) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (trial >= {1'b0, den_ff}) begin
            rem_ff <= DW'(trial - {1'b0, den_ff});
            quot   <= {quot[NW-2:0], 1'b1};
         end else begin
            rem_ff <= trial[DW-1:0];
            quot   <= {quot[NW-2:0], 1'b0};
         end
      end
   end
endmodule
`default_nettype wire

### sv/bdis_ctrl.sv
`default_nettype none
module bdis_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire bdis_pkg::bdis_sts_type sts,
   output bdis_pkg::bdis_cmd_type     cmd
);
   import bdis_pkg::*;

   typedef enum logic [2:0] {
      IDLE, EMA, SCAN0, SCAN, DIV, DIVWAIT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      busy_ok;

   assign rsp_valid = rsp_valid_ff;
   assign busy_ok   = (state_ff == IDLE);
   assign req_stall = !busy_ok;

   always_comb begin
      cmd = '0;
      cmd.load = busy_ok && req_valid;
      unique case (state_ff)
         EMA:     cmd.ema_apply = sts.stored;
         SCAN0:   cmd.scan_start = 1'b1;
         SCAN:    cmd.scan_step = 1'b1;
         DIV:     cmd.div_start = 1'b1;
         DIVWAIT: cmd.rsp_load = !sts.div_busy && !(rsp_valid_ff && rsp_stall);
         default: ;
      endcase
   end

   // hold a stalled result, raise valid on a new one
   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);

   // sequence one transaction: load, average, then scan and divide on last
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            IDLE:    if (req_valid) state_ff <= EMA;
            EMA:     state_ff <= sts.last ? SCAN0 : IDLE;
            SCAN0:   state_ff <= SCAN;
            SCAN:    if (sts.scan_done) state_ff <= DIV;
            DIV:     state_ff <= DIVWAIT;
            DIVWAIT: if (cmd.rsp_load) state_ff <= IDLE;
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

### sv/bdis_dp.sv
`default_nettype none
module bdis_dp #(
   parameter int BATCH_DEPTH = 1024
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire bdis_pkg::req_payload_type req_data,
   input  wire bdis_pkg::bdis_cmd_type  cmd,
   output bdis_pkg::bdis_sts_type       sts,
   input  wire logic [11:0]             thr,
   input  wire logic [11:0]             margin,
   input  wire logic [15:0]             alpha,
   output bdis_pkg::rsp_payload_type    rsp_data
);
   import bdis_pkg::*;

   localparam int AW = $clog2(BATCH_DEPTH);
   localparam int CW = $clog2(BATCH_DEPTH + 1);

   logic [CW-1:0] count_ff;
   logic [47:0]   prev_ff;
   logic          have_prev_ff;
   logic [27:0]   avg_ff;
   logic [57:0]   sum_ff;
   logic [47:0]   lo_gap_ff, hi_gap_ff;
   logic [11:0]   lo_lvl_ff, hi_lvl_ff;
   logic          stored_ff, last_ff;
   logic signed [46:0] prod_ff;
   logic          in_dip_ff;
   logic [9:0]    dips_ff;
   logic [CW-1:0] rd_ptr_ff;
   logic          chk_ff;
   logic [AW-1:0] rd_addr;
   logic [11:0]   rd_data;
   logic          full;
   logic [47:0]   ts, gap;
   logic [11:0]   code;
   logic signed [29:0] diff;
   logic signed [46:0] adj;
   logic signed [30:0] offset, start_b, stop_b;
   logic          div_busy;
   logic [57:0]   quot;

   assign full = (count_ff == CW'(BATCH_DEPTH));
   assign code = req_data.sample_code;
   assign ts   = req_data.timestamp_ns;
   assign gap  = have_prev_ff ? ts - prev_ff : 48'd0;
   assign diff = $signed({2'b00, code, 16'd0}) - $signed({2'b00, avg_ff});

   // floor of product over 2^16 is an arithmetic shift
   assign adj = prod_ff >>> 16;

   // keep sample, gap/level stats on load; average; clear on result
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         avg_ff       <= '0;
         sum_ff       <= '0;
         lo_gap_ff    <= '0;
         hi_gap_ff    <= '0;
         lo_lvl_ff    <= '0;
         hi_lvl_ff    <= '0;
         stored_ff    <= 1'b0;
         last_ff      <= 1'b0;
      end else begin
         if (cmd.load) begin
            stored_ff <= !full;
            last_ff   <= req_data.last;
            prod_ff   <= $signed(diff) * $signed({1'b0, alpha});
            if (!full) begin
               have_prev_ff <= 1'b1;
               prev_ff      <= ts;
               count_ff     <= count_ff + 1'b1;
               if (count_ff == '0) begin
                  lo_gap_ff <= gap;
                  hi_gap_ff <= gap;
                  lo_lvl_ff <= code;
                  hi_lvl_ff <= code;
                  sum_ff    <= 58'(gap);
               end else begin
                  if (gap < lo_gap_ff) lo_gap_ff <= gap;
                  if (gap > hi_gap_ff) hi_gap_ff <= gap;
                  if (code < lo_lvl_ff) lo_lvl_ff <= code;
                  if (code > hi_lvl_ff) hi_lvl_ff <= code;
                  sum_ff <= sum_ff + 58'(gap);
               end
            end
         end
         if (cmd.ema_apply) begin
            avg_ff <= 28'(avg_ff + adj[27:0]);
         end
         if (cmd.rsp_load) begin
            count_ff <= '0;
         end
      end
   end

   bdis_ram #(.WIDTH(12), .DEPTH(BATCH_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (cmd.load && !full),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (code),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_addr = cmd.scan_start ? '0 : rd_ptr_ff[AW-1:0];

   // dip scan: one stored sample per cycle against the final average
   assign offset  = $signed({3'b000, rd_data, 16'd0}) - $signed({3'b000, avg_ff});
   assign start_b = $signed({3'b000, thr, 16'd0});
   assign stop_b  = $signed({{3{1'b0}}, thr, 16'd0}) - $signed({3'b000, margin, 16'd0});

   logic [30:0] adist;
   assign adist = offset[30] ? 31'(-offset) : offset;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_dip_ff <= 1'b0;
         dips_ff   <= '0;
         rd_ptr_ff <= '0;
         chk_ff    <= 1'b0;
      end else if (cmd.scan_start) begin
         in_dip_ff <= 1'b0;
         dips_ff   <= '0;
         rd_ptr_ff <= CW'(1);
         chk_ff    <= (count_ff != '0);
      end else if (cmd.scan_step) begin
         rd_ptr_ff <= rd_ptr_ff + 1'b1;
         chk_ff    <= (rd_ptr_ff < count_ff);
         if (chk_ff) begin
            if (in_dip_ff) begin
               if ($signed(adist) < stop_b) in_dip_ff <= 1'b0;
            end else if ($signed(adist) > start_b) begin
               in_dip_ff <= 1'b1;
               dips_ff   <= dips_ff + 1'b1;
            end
         end
      end
   end

   bdis_div #(.NW(58), .DW(CW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer (count_ff == '0 ? 58'd0 : sum_ff),
      .denom (count_ff == '0 ? CW'(1) : count_ff),
      .busy  (div_busy),
      .quot  (quot)
   );

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data.dip_count     <= dips_ff;
         rsp_data.shortest_gap  <= lo_gap_ff;
         rsp_data.longest_gap   <= hi_gap_ff;
         rsp_data.mean_interval <= quot[47:0];
         rsp_data.min_sample    <= lo_lvl_ff;
         rsp_data.max_sample    <= hi_lvl_ff;
         rsp_data.average_level <= avg_ff;
      end
   end

   always_comb begin
      sts.stored    = stored_ff;
      sts.last      = last_ff;
      sts.scan_done = cmd.scan_step && !chk_ff;
      sts.div_busy  = div_busy;
   end
endmodule
`default_nettype wire

### sv/bdis_checker.sv
`default_nettype none
module bdis_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic [11:0] min_s,
   input wire logic [11:0] max_s
);
   // a stalled result stays valid
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result dropped");
   // each accepted sample blocks the next cycle
   a_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall) else $error("back to back accept");
   // a presented result orders min below max
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> min_s <= max_s) else $error("min above max");
   // nothing presented right after reset
   a_rst: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid) else $error("valid after reset");
endmodule

bind batch_dip_and_interval_stats bdis_checker u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .min_s     (rsp_data.min_sample),
   .max_s     (rsp_data.max_sample)
);
`default_nettype wire

### tb/sv/batch_dip_and_interval_stats_test.sv
`default_nettype none
module batch_dip_and_interval_stats_test;
   import bdis_pkg::*;

   localparam int STORE_DEPTH = 1024;
   localparam int IDLE_LIMIT  = 20000;
   localparam logic [47:0] TS_MAX = 48'hFFFF_FFFF_FFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = CSR_DIP_THRESHOLD;
   logic [15:0] csr_data = '0;

   batch_dip_and_interval_stats dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor copy of the block state and registers
   logic [11:0] level_store [STORE_DEPTH];
   int          stored_count;
   logic [47:0] prior_stamp;
   bit          prior_seen;
   logic [27:0] smooth_level;
   logic [57:0] gap_total;
   logic [47:0] gap_low, gap_high;
   logic [11:0] level_low, level_high;
   logic [11:0] thr_cfg;
   logic [11:0] margin_cfg;
   logic [15:0] alpha_cfg;

   rsp_payload_type batch_summaries [$];
   int  errors = 0;
   int  idle_cycles = 0;
   bit  calm = 1'b0;
   int  hold_cycles = 0;
   logic [47:0] stamp_now = '0;

   // fold one sample into the statistics; return 1 when the batch closes
   function automatic bit fold_sample(input req_payload_type s, output rsp_payload_type r);
      logic [47:0] gap;
      longint diff, prod, spread, start_bound, stop_bound;
      int dips;
      bit dipping;
      r = '0;
      if (stored_count < STORE_DEPTH) begin
         if (!prior_seen) begin
            prior_stamp = s.timestamp_ns;
            prior_seen = 1'b1;
         end
         gap = s.timestamp_ns - prior_stamp;
         prior_stamp = s.timestamp_ns;
         if (stored_count == 0) begin
            gap_low = gap; gap_high = gap;
            level_low = s.sample_code; level_high = s.sample_code;
            gap_total = '0;
         end
         if (gap < gap_low) gap_low = gap;
         if (gap > gap_high) gap_high = gap;
         if (s.sample_code < level_low) level_low = s.sample_code;
         if (s.sample_code > level_high) level_high = s.sample_code;
         gap_total = gap_total + 58'(gap);
         diff = longint'(s.sample_code) * 65536 - longint'(smooth_level);
         prod = diff * longint'(alpha_cfg);
         smooth_level = 28'(longint'(smooth_level) + (prod >>> 16));
         level_store[stored_count] = s.sample_code;
         stored_count++;
      end
      if (!s.last) return 1'b0;
      // hysteresis scan over the stored batch
      start_bound = longint'(thr_cfg) * 65536;
      stop_bound = (longint'(thr_cfg) - longint'(margin_cfg)) * 65536;
      dipping = 1'b0;
      dips = 0;
      for (int i = 0; i < stored_count; i++) begin
         spread = longint'(level_store[i]) * 65536 - longint'(smooth_level);
         if (spread < 0) spread = -spread;
         if (dipping) begin
            if (spread < stop_bound) dipping = 1'b0;
         end else if (spread > start_bound) begin
            dipping = 1'b1;
            dips++;
         end
      end
      r.dip_count = 10'(dips);
      r.shortest_gap = gap_low;
      r.longest_gap = gap_high;
      r.mean_interval = (stored_count != 0) ? 48'(gap_total / 58'(stored_count)) : '0;
      r.min_sample = level_low;
      r.max_sample = level_high;
      r.average_level = smooth_level;
      stored_count = 0;
      return 1'b1;
   endfunction

   // offer one transaction and hold it until taken
   task automatic send_sample(input req_payload_type s, input bit typed,
                              input rsp_payload_type typed_sum);
      rsp_payload_type r;
      if (!calm && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= s;
      do @(posedge clock); while (req_stall);
      if (fold_sample(s, r)) batch_summaries.push_back(typed ? typed_sum : r);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_DIP_THRESHOLD:  thr_cfg = val[11:0];
         CSR_RELEASE_MARGIN: margin_cfg = val[11:0];
         CSR_EMA_ALPHA:      alpha_cfg = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // wait out every pending summary before touching registers
   task automatic drain();
      req_valid <= 1'b0;
      while (batch_summaries.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   function automatic logic [47:0] next_stamp();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) stamp_now = stamp_now + 48'($urandom_range(1, 2000));
      else if (pick < 80) ;
      else if (pick < 92) stamp_now = stamp_now + {16'($urandom), $urandom};
      else stamp_now = {16'($urandom), $urandom};
      return stamp_now;
   endfunction

   task automatic random_batch(input int len);
      req_payload_type s;
      rsp_payload_type none;
      none = '0;
      for (int i = 0; i < len; i++) begin
         s.sample_code = ($urandom_range(0, 3) == 0) ? 12'($urandom)
                         : 12'(2048 + $urandom_range(0, 600) - 300);
         s.timestamp_ns = next_stamp();
         s.last = (i == len - 1);
         send_sample(s, 1'b0, none);
      end
   endtask

   // receiver: random stall, plus one long hold on request
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 10);
      end
   end

   // compare each accepted summary against the oldest pending one
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (batch_summaries.size() == 0) begin
            $display("%0t: unexpected summary %h", $time, rsp_data);
            errors++;
         end else begin
            want = batch_summaries.pop_front();
            if (rsp_data.dip_count !== want.dip_count) begin
               $display("%0t: dip_count exp %0d got %0d", $time, want.dip_count,
                        rsp_data.dip_count);
               errors++;
            end
            if (rsp_data.shortest_gap !== want.shortest_gap) begin
               $display("%0t: shortest_gap exp %0d got %0d", $time, want.shortest_gap,
                        rsp_data.shortest_gap);
               errors++;
            end
            if (rsp_data.longest_gap !== want.longest_gap) begin
               $display("%0t: longest_gap exp %0d got %0d", $time, want.longest_gap,
                        rsp_data.longest_gap);
               errors++;
            end
            if (rsp_data.mean_interval !== want.mean_interval) begin
               $display("%0t: mean_interval exp %0d got %0d", $time, want.mean_interval,
                        rsp_data.mean_interval);
               errors++;
            end
            if (rsp_data.min_sample !== want.min_sample) begin
               $display("%0t: min_sample exp %0d got %0d", $time, want.min_sample,
                        rsp_data.min_sample);
               errors++;
            end
            if (rsp_data.max_sample !== want.max_sample) begin
               $display("%0t: max_sample exp %0d got %0d", $time, want.max_sample,
                        rsp_data.max_sample);
               errors++;
            end
            if (rsp_data.average_level !== want.average_level) begin
               $display("%0t: average_level exp %0d got %0d", $time, want.average_level,
                        rsp_data.average_level);
               errors++;
            end
         end
      end
   end

   // watchdog: end the run after too long without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL batch_dip_and_interval_stats");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   typedef struct {
      logic [11:0] code;
      logic [47:0] stamp;
      bit          last;
      bit          typed;
      rsp_payload_type summary;
   } stim_row_type;

   stim_row_type directed [] = '{
      // first sample ever: zero interval, zero average
      '{12'd0, 48'd0, 1'b1, 1'b1, '0},
      // extremes: full-scale code, largest timestamp
      '{12'd4095, TS_MAX, 1'b1, 1'b1,
        '{10'd1, TS_MAX, TS_MAX, TS_MAX, 12'd4095, 12'd4095, 28'd270270}},
      // decreasing timestamp wraps to a small gap
      '{12'd100, 48'd5, 1'b0, 1'b0, '0},
      '{12'd4095, 48'd10, 1'b0, 1'b0, '0},
      '{12'd4095, 48'd10, 1'b0, 1'b0, '0},
      '{12'd0, 48'd30, 1'b0, 1'b0, '0},
      '{12'd2048, 48'd31, 1'b1, 1'b0, '0},
      // hysteresis: enter, hover, release, enter again
      '{12'd0, 48'd40, 1'b0, 1'b0, '0},
      '{12'd3000, 48'd41, 1'b0, 1'b0, '0},
      '{12'd3000, 48'd42, 1'b0, 1'b0, '0},
      '{12'd10, 48'd43, 1'b0, 1'b0, '0},
      '{12'd12, 48'd60, 1'b0, 1'b0, '0},
      '{12'd3500, 48'd61, 1'b0, 1'b0, '0},
      '{12'd2, 48'd61, 1'b1, 1'b0, '0},
      '{12'hAAA, 48'h5555_5555_5555, 1'b0, 1'b0, '0},
      '{12'h555, 48'hAAAA_AAAA_AAAA, 1'b1, 1'b0, '0}
   };

   initial begin
      req_payload_type s;
      stored_count = 0; prior_stamp = '0; prior_seen = 1'b0;
      smooth_level = '0; gap_total = '0;
      gap_low = '0; gap_high = '0; level_low = '0; level_high = '0;
      thr_cfg = DIP_THRESHOLD_RESET;
      margin_cfg = RELEASE_MARGIN_RESET;
      alpha_cfg = EMA_ALPHA_RESET;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table at reset register values
      foreach (directed[i]) begin
         s.sample_code = directed[i].code;
         s.timestamp_ns = directed[i].stamp;
         s.last = directed[i].last;
         send_sample(s, directed[i].typed, directed[i].summary);
      end
      stamp_now = 48'd100;
      drain();

      // margin above threshold and the fastest average
      write_reg(CSR_DIP_THRESHOLD, 16'd0);
      write_reg(CSR_RELEASE_MARGIN, 16'd4095);
      write_reg(CSR_EMA_ALPHA, 16'hFFFF);
      for (int b = 0; b < 10; b++) random_batch($urandom_range(1, 12));
      drain();

      // widest threshold, frozen average; hold the receiver off meanwhile
      write_reg(CSR_DIP_THRESHOLD, 16'd4095);
      write_reg(CSR_RELEASE_MARGIN, 16'd0);
      write_reg(CSR_EMA_ALPHA, 16'd0);
      hold_cycles = 3000;
      for (int b = 0; b < 15; b++) random_batch($urandom_range(1, 10));
      drain();

      // realistic settings: overfill one batch, then a quiet stretch
      write_reg(CSR_DIP_THRESHOLD, 16'd150);
      write_reg(CSR_RELEASE_MARGIN, 16'd60);
      write_reg(CSR_EMA_ALPHA, 16'd20000);
      random_batch(STORE_DEPTH + 6);
      calm = 1'b1;
      for (int b = 0; b < 15; b++) random_batch($urandom_range(2, 12));
      calm = 1'b0;
      drain();

      // random register values
      for (int ph = 0; ph < 4; ph++) begin
         write_reg(CSR_DIP_THRESHOLD, 16'($urandom_range(0, 600)));
         write_reg(CSR_RELEASE_MARGIN, 16'($urandom_range(0, 700)));
         write_reg(CSR_EMA_ALPHA, 16'($urandom));
         for (int b = 0; b < 12; b++) random_batch($urandom_range(1, 16));
         drain();
      end

      if (errors == 0) begin
         $display("PASS batch_dip_and_interval_stats");
      end else begin
         $display("FAIL batch_dip_and_interval_stats");
      end
      $finish;
   end
endmodule
`default_nettype wire
